### hw/rtl/vofn_pkg.sv
// ----------------------------------------------------------------------------
// vofn_pkg
// Shared types, widths and a helper function of the interface normal block.
// ----------------------------------------------------------------------------
package vofn_pkg;

  // Field and datapath widths.
  localparam int unsigned FracW    = 16;  // volume fraction, unsigned Q0.16
  localparam int unsigned NrmW     = 16;  // normal component, signed Q1.15
  localparam int unsigned GradW    = 22;  // signed raw gradient component
  localparam int unsigned MagW     = 20;  // gradient magnitude
  localparam int unsigned SqW      = 40;  // squared magnitude
  localparam int unsigned SumW     = 42;  // sum of the three squares
  localparam int unsigned AccW     = 80;  // normalizer remainder width
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned SizeXYW  = 7;
  localparam int unsigned SizeZW   = 12;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_e;

  // Request to the normalizer: one component at a time.
  typedef struct packed {
    logic            start;
    logic            neg;
    logic [SqW-1:0]  g2;
    logic [SumW-1:0] s;
  } norm_req_t;

  // Normalizer answer.
  typedef struct packed {
    logic                   done;
    logic signed [NrmW-1:0] value;
  } norm_rsp_t;

  // Contribution of one stencil tap to one gradient component. p_own is the
  // tap offset code along the component axis (0 is +1, 2 is -1), p_a and p_b
  // the codes along the transverse axes (1 is the centre, weight 2).
  function automatic logic signed [GradW-1:0] tap_term(
    input logic [FracW-1:0] s,
    input logic [1:0]       p_own,
    input logic [1:0]       p_a,
    input logic [1:0]       p_b
  );
    logic signed [GradW-1:0] v;
    v = signed'({{(GradW-FracW){1'b0}}, s});
    if (p_a == 2'd1) v = v <<< 1;
    if (p_b == 2'd1) v = v <<< 1;
    if (p_own == 2'd0) begin
      tap_term = v;
    end else if (p_own == 2'd2) begin
      tap_term = -v;
    end else begin
      tap_term = '0;
    end
  endfunction

endpackage

### hw/rtl/vofn_ram.sv
// ----------------------------------------------------------------------------
// vofn_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vofn_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/vofn_norm.sv
// ----------------------------------------------------------------------------
// vofn_norm
// Iterative normalizer: r = round(2^15 * |g| / sqrt(S)), one result bit per
// cycle, by shift and add only, then sign and saturation.
// ----------------------------------------------------------------------------
module vofn_norm
  import vofn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  norm_req_t req_i,
  output norm_rsp_t rsp_o
);

  localparam int unsigned BitW = $clog2(NrmW);

  // The remainder e holds 2^32*g^2 - (2r-1)^2*S. For the trial bit b,
  // a holds (2r-1)*S*2^(b+2) and b holds S*2^(2b+2).
  logic                   busy_q;
  logic                   done_q;
  logic [BitW-1:0]        bit_q;
  logic signed [AccW-1:0] e_q;
  logic signed [AccW-1:0] a_q;
  logic signed [AccW-1:0] b_q;
  logic [NrmW-1:0]        r_q;
  logic                   neg_q;
  logic                   zero_q;
  logic signed [NrmW-1:0] value_q;

  logic signed [AccW-1:0] trial;
  logic                   fit;
  logic [NrmW-1:0]        r_d;
  logic signed [NrmW-1:0] value_d;

  // Trial subtraction for the current bit.
  always_comb begin
    trial = e_q - a_q - b_q;
    fit   = !trial[AccW-1];
    r_d   = fit ? (r_q | (NrmW'(1) << bit_q)) : r_q;
  end

  // Sign, saturation of plus one, and the zero vector.
  always_comb begin
    if (zero_q) begin
      value_d = '0;
    end else if (neg_q) begin
      value_d = signed'(NrmW'(~r_d + 1'b1));
    end else if (r_d[NrmW-1]) begin
      value_d = signed'({1'b0, {(NrmW-1){1'b1}}});
    end else begin
      value_d = signed'(r_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        bit_q  <= BitW'(NrmW - 1);
        e_q    <= signed'((AccW'(req_i.g2) << (2 * NrmW)) - AccW'(req_i.s));
        a_q    <= signed'(AccW'(0) - (AccW'(req_i.s) << (NrmW + 1)));
        b_q    <= signed'(AccW'(req_i.s) << (2 * NrmW));
        r_q    <= '0;
        neg_q  <= req_i.neg;
        zero_q <= (req_i.s == '0);
      end else if (busy_q) begin
        if (fit) begin
          e_q <= trial;
          a_q <= (a_q >>> 1) + b_q;
        end else begin
          a_q <= a_q >>> 1;
        end
        b_q <= b_q >>> 2;
        r_q <= r_d;
        if (bit_q == '0) begin
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
          value_q <= value_d;
        end else begin
          bit_q <= bit_q - 1'b1;
        end
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = value_q;

endmodule

### hw/rtl/vof_interface_normal_3d.sv
// ----------------------------------------------------------------------------
// vof_interface_normal_3d
// Youngs interface normal of a streamed 3D volume-fraction grid. Samples
// arrive in raster order; a line-store RAM holds 2 planes, 2 rows and 2 samples.
// ----------------------------------------------------------------------------
//   Channel  | Signals                                   | Dir
//   input    | in_valid_i, in_stall_o, fraction_i        | in
//   result   | out_valid_o, out_stall_i, normal_*_o,     | out
//            | cell_*_o, volume_done_o                   |
//   config   | cfg_valid_i, cfg_ready_o, cfg_index_i,    | in
//            | cfg_data_i                                |
//
// A border sample is written to the line store at once.
// An interior sample takes 27 RAM reads through the single
// read port, three squarings on one multiplier and three passes of
// the bit-serial normalizer.
// Reset clears sizes to 64 and the raster position; the line store is not
// cleared. A held result blocks the input only once the next result is ready,
// and a pending register write holds off the input.
// ----------------------------------------------------------------------------
module vof_interface_normal_3d
  import vofn_pkg::*;
#(
  parameter int unsigned MAX_X = 64,
  parameter int unsigned MAX_Y = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [FracW-1:0]        fraction_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [NrmW-1:0]  normal_x_o,
  output logic signed [NrmW-1:0]  normal_y_o,
  output logic signed [NrmW-1:0]  normal_z_o,
  output logic [5:0]              cell_x_o,
  output logic [5:0]              cell_y_o,
  output logic [SizeZW-1:0]       cell_z_o,
  output logic                    volume_done_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned Depth = 2 * MAX_X * MAX_Y + 2 * MAX_X + 2;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned DistW = $clog2(Depth + 1);
  localparam int unsigned XSW   = $clog2(MAX_X + 1);
  localparam int unsigned YSW   = $clog2(MAX_Y + 1);
  localparam int unsigned PXW   = $clog2(MAX_X);
  localparam int unsigned PYW   = $clog2(MAX_Y);
  localparam int unsigned PlW   = $clog2(MAX_X * MAX_Y + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_SQUARE,
    ST_SUM,
    ST_NSTART,
    ST_NWAIT,
    ST_PUT
  } state_e;

  state_e                  state_q;
  logic [SizeXYW-1:0]      size_x_q, size_y_q;
  logic [SizeZW-1:0]       size_z_q;
  logic [PlW-1:0]          sxy_q;
  logic [PXW-1:0]          pos_x_q, cx_q;
  logic [PYW-1:0]          pos_y_q, cy_q;
  logic [SizeZW-1:0]       pos_z_q, cz_q;
  logic                    last_q;
  logic [AddrW-1:0]        wp_q;
  logic [FracW-1:0]        cur_q;
  logic [1:0]              px_q, py_q, pz_q;
  logic                    tag_vld_q;
  logic [1:0]              tpx_q, tpy_q, tpz_q;
  logic signed [GradW-1:0] gx_q, gy_q, gz_q;
  logic [1:0]              comp_q;
  logic [SqW-1:0]          sq_q [3];
  logic [SumW-1:0]         s_q;
  logic signed [NrmW-1:0]  nrm_q [3];
  logic                    out_valid_q;
  logic signed [NrmW-1:0]  normal_x_q, normal_y_q, normal_z_q;
  logic [5:0]              cell_x_q, cell_y_q;
  logic [SizeZW-1:0]       cell_z_q;
  logic                    volume_done_q;

  logic [XSW-1:0]          sx_c;
  logic [YSW-1:0]          sy_c;
  logic [SizeZW-1:0]       sz_c;
  logic                    in_xfer, cfg_xfer, cfg_hit;
  logic                    pos_bad, interior, last_c;
  logic                    wrap_x, wrap_y, wrap_z;
  logic [PXW-1:0]          pex, nx;
  logic [PYW-1:0]          pey, ny;
  logic [SizeZW-1:0]       pez, nz;
  logic [DistW-1:0]        tap_dist, wp_ext;
  logic [AddrW-1:0]        raddr;
  logic                    mem_we;
  logic [FracW-1:0]        mem_wdata, rdata, tap;
  logic [AddrW-1:0]        wp_next;
  logic signed [GradW-1:0] g_sel;
  logic [MagW-1:0]         mag_sel;
  logic                    read_last;
  norm_req_t               nreq;
  norm_rsp_t               nrsp;

  // A pending register write takes precedence over the input.
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  // Sizes as used, clamped to the supported range.
  always_comb begin
    if (size_x_q < SizeXYW'(3)) begin
      sx_c = XSW'(3);
    end else if (32'(size_x_q) > MAX_X) begin
      sx_c = XSW'(MAX_X);
    end else begin
      sx_c = XSW'(size_x_q);
    end
    if (size_y_q < SizeXYW'(3)) begin
      sy_c = YSW'(3);
    end else if (32'(size_y_q) > MAX_Y) begin
      sy_c = YSW'(MAX_Y);
    end else begin
      sy_c = YSW'(size_y_q);
    end
    sz_c = (size_z_q < SizeZW'(3)) ? SizeZW'(3) : size_z_q;
  end

  // Raster position of the arriving sample and the position after it.
  always_comb begin
    pos_bad  = (XSW'(pos_x_q) >= sx_c) || (YSW'(pos_y_q) >= sy_c) || (pos_z_q >= sz_c);
    pex      = pos_bad ? '0 : pos_x_q;
    pey      = pos_bad ? '0 : pos_y_q;
    pez      = pos_bad ? '0 : pos_z_q;
    interior = (pex >= PXW'(2)) && (pey >= PYW'(2)) && (pez >= SizeZW'(2));
    wrap_x   = (XSW'(pex) == sx_c - 1'b1);
    wrap_y   = (YSW'(pey) == sy_c - 1'b1);
    wrap_z   = (pez == sz_c - 1'b1);
    last_c   = wrap_x && wrap_y && wrap_z;
    nx       = wrap_x ? '0 : pex + 1'b1;
    ny       = pey;
    nz       = pez;
    if (wrap_x) begin
      ny = wrap_y ? '0 : pey + 1'b1;
      if (wrap_y) begin
        nz = wrap_z ? '0 : pez + 1'b1;
      end
    end
  end

  // Line-store address of the tap (1-px, 1-py, 1-pz) behind the write pointer.
  always_comb begin
    tap_dist = DistW'(px_q);
    if (py_q == 2'd1) tap_dist = tap_dist + DistW'(sx_c);
    if (py_q == 2'd2) tap_dist = tap_dist + (DistW'(sx_c) << 1);
    if (pz_q == 2'd1) tap_dist = tap_dist + DistW'(sxy_q);
    if (pz_q == 2'd2) tap_dist = tap_dist + (DistW'(sxy_q) << 1);
    wp_ext = DistW'(wp_q);
    if (wp_ext >= tap_dist) begin
      raddr = AddrW'(wp_ext - tap_dist);
    end else begin
      raddr = AddrW'(wp_ext + DistW'(Depth) - tap_dist);
    end
    read_last = (px_q == 2'd2) && (py_q == 2'd2) && (pz_q == 2'd2);
  end

  // Line-store write: a border sample at once, an interior one after its reads.
  assign mem_we    = (in_xfer && !interior) || (state_q == ST_DRAIN);
  assign mem_wdata = (state_q == ST_DRAIN) ? cur_q : fraction_i;
  assign wp_next   = (32'(wp_q) == Depth - 1) ? '0 : wp_q + 1'b1;
  assign cfg_hit   = cfg_xfer && ((cfg_index_i == CFG_SIZE_X) ||
                                  (cfg_index_i == CFG_SIZE_Y) ||
                                  (cfg_index_i == CFG_SIZE_Z));

  vofn_ram #(
    .Width(FracW),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(wp_q),
    .wdata_i(mem_wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // The centre-plus-one tap is the held sample itself.
  assign tap = ((tpx_q == 2'd0) && (tpy_q == 2'd0) && (tpz_q == 2'd0)) ? cur_q : rdata;

  // Component selected for squaring and normalizing.
  always_comb begin
    unique case (comp_q)
      2'd0:    g_sel = gx_q;
      2'd1:    g_sel = gy_q;
      default: g_sel = gz_q;
    endcase
    mag_sel = g_sel[GradW-1] ? MagW'(-g_sel) : MagW'(g_sel);
  end

  assign nreq.start = (state_q == ST_NSTART);
  assign nreq.neg   = g_sel[GradW-1];
  assign nreq.g2    = sq_q[comp_q];
  assign nreq.s     = s_q;

  vofn_norm u_norm (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (nreq),
    .rsp_o (nrsp)
  );

  // Sequencer, line-store pointer, accumulators and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_x_q    <= SizeXYW'(64);
      size_y_q    <= SizeXYW'(64);
      size_z_q    <= SizeZW'(64);
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      wp_q        <= '0;
      tag_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sxy_q     <= PlW'(sx_c) * PlW'(sy_c);
      tag_vld_q <= (state_q == ST_READ);
      tpx_q     <= px_q;
      tpy_q     <= py_q;
      tpz_q     <= pz_q;
      if (mem_we) begin
        wp_q <= wp_next;
      end
      if (tag_vld_q) begin
        gx_q <= gx_q + tap_term(tap, tpx_q, tpy_q, tpz_q);
        gy_q <= gy_q + tap_term(tap, tpy_q, tpx_q, tpz_q);
        gz_q <= gz_q + tap_term(tap, tpz_q, tpx_q, tpy_q);
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // Register writes restart the volume.
      if (cfg_xfer) begin
        unique case (cfg_index_i)
          CFG_SIZE_X: size_x_q <= cfg_data_i[SizeXYW-1:0];
          CFG_SIZE_Y: size_y_q <= cfg_data_i[SizeXYW-1:0];
          CFG_SIZE_Z: size_z_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (cfg_hit) begin
            pos_x_q <= '0;
            pos_y_q <= '0;
            pos_z_q <= '0;
          end else if (in_xfer) begin
            pos_x_q <= nx;
            pos_y_q <= ny;
            pos_z_q <= nz;
            cur_q   <= fraction_i;
            cx_q    <= pex;
            cy_q    <= pey;
            cz_q    <= pez;
            last_q  <= last_c;
            px_q    <= '0;
            py_q    <= '0;
            pz_q    <= '0;
            gx_q    <= '0;
            gy_q    <= '0;
            gz_q    <= '0;
            if (interior) begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (px_q == 2'd2) begin
            px_q <= '0;
            if (py_q == 2'd2) begin
              py_q <= '0;
              pz_q <= pz_q + 1'b1;
            end else begin
              py_q <= py_q + 1'b1;
            end
          end else begin
            px_q <= px_q + 1'b1;
          end
          if (read_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          comp_q  <= '0;
          state_q <= ST_SQUARE;
        end
        ST_SQUARE: begin
          sq_q[comp_q] <= SqW'(mag_sel) * SqW'(mag_sel);
          if (comp_q == 2'd2) begin
            state_q <= ST_SUM;
          end else begin
            comp_q <= comp_q + 1'b1;
          end
        end
        ST_SUM: begin
          s_q     <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
          comp_q  <= '0;
          state_q <= ST_NSTART;
        end
        ST_NSTART: begin
          state_q <= ST_NWAIT;
        end
        ST_NWAIT: begin
          if (nrsp.done) begin
            nrm_q[comp_q] <= nrsp.value;
            if (comp_q == 2'd2) begin
              state_q <= ST_PUT;
            end else begin
              comp_q  <= comp_q + 1'b1;
              state_q <= ST_NSTART;
            end
          end
        end
        ST_PUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            normal_x_q    <= nrm_q[0];
            normal_y_q    <= nrm_q[1];
            normal_z_q    <= nrm_q[2];
            cell_x_q      <= 6'(cx_q - 1'b1);
            cell_y_q      <= 6'(cy_q - 1'b1);
            cell_z_q      <= cz_q - 1'b1;
            volume_done_q <= last_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign normal_x_o    = normal_x_q;
  assign normal_y_o    = normal_y_q;
  assign normal_z_o    = normal_z_q;
  assign cell_x_o      = cell_x_q;
  assign cell_y_o      = cell_y_q;
  assign cell_z_o      = cell_z_q;
  assign volume_done_o = volume_done_q;

endmodule

### hw/rtl/vofn_checker.sv
// ----------------------------------------------------------------------------
// vofn_checker
// Port-level checks of the interface normal block, bound to the top level.
// ----------------------------------------------------------------------------
module vofn_checker
  import vofn_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [NrmW-1:0] normal_x_o,
  input logic [5:0]             cell_x_o,
  input logic [5:0]             cell_y_o,
  input logic [SizeZW-1:0]      cell_z_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its x normal and its x cell index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(normal_x_o) && $stable(cell_x_o))
    else $error("stalled result changed");

  // Results belong to interior cells only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cell_x_o != 6'd0) && (cell_y_o != 6'd0) && (cell_z_o != '0))
    else $error("result for a border cell");

  // A new result only follows a busy period with the input held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a computation");

endmodule

bind vof_interface_normal_3d vofn_checker u_vofn_checker (.*);
